/* rtl/thin_multipole_bend_kick_top_macros.svh */
// Assertion macros for the thin multipole bend kick block.
// Both macros expect clk and rst_n in scope at the point of use.
`ifndef THIN_MULTIPOLE_BEND_KICK_TOP_MACROS_SVH
`define THIN_MULTIPOLE_BEND_KICK_TOP_MACROS_SVH
`ifndef SYNTH
`define TMBK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TMBK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMBK_ASSERT_IMP(label, ante, cons, msg)
`define TMBK_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/tmbk_pkg.sv */
`timescale 1ns / 1ps
package tmbk_pkg;

    localparam int VAL_W       = 48;
    localparam int HALF_W      = VAL_W / 2;
    localparam int PART_W      = 2 * HALF_W + 2;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int SUM_W       = VAL_W + 2;
    localparam int NUM_COEF    = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int FMUL_STAGES = 3;
    localparam int STEP_STAGES = FMUL_STAGES + 1;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DIPOLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_QUAD   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_SEXT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_OCT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_DIPOLE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_QUAD     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_SEXT     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_OCT      = 4'd7;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [NUM_COEF-1:0][VAL_W-1:0] coef_arr_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        coef_arr_t normal;
        coef_arr_t skew;
    } coef_t;

    typedef struct packed {
        val_t pos_x;
        val_t angle_x;
        val_t pos_y;
        val_t angle_y;
        val_t energy_dev;
        val_t path_len;
        logic bunch_end;
    } particle_t;

    typedef struct packed {
        val_t new_pos_x;
        val_t new_angle_x;
        val_t new_pos_y;
        val_t new_angle_y;
        val_t new_energy_dev;
        val_t new_path_len;
        logic bunch_end_out;
    } result_t;

    // A particle on its way through the Horner chain, with the running field sum.
    typedef struct packed {
        particle_t part;
        val_t      re;
        val_t      im;
    } work_t;

    function automatic sum_t ext(input val_t v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic val_t sat_sum(input sum_t v);
        if (!v[SUM_W-1] && (|v[SUM_W-2:VAL_W-1])) begin
            return VAL_MAX;
        end
        if (v[SUM_W-1] && !(&v[SUM_W-2:VAL_W-1])) begin
            return VAL_MIN;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

/* rtl/tmbk_cfg.sv */
`timescale 1ns / 1ps
module tmbk_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmbk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  tmbk_pkg::val_t                      cfg_data,
    output tmbk_pkg::coef_t                     coefs
);

    tmbk_pkg::coef_t coef_reg;
    tmbk_pkg::coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coefs     = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tmbk_pkg::REG_NORMAL_DIPOLE: coef_next.normal[0] = cfg_data;
                tmbk_pkg::REG_NORMAL_QUAD:   coef_next.normal[1] = cfg_data;
                tmbk_pkg::REG_NORMAL_SEXT:   coef_next.normal[2] = cfg_data;
                tmbk_pkg::REG_NORMAL_OCT:    coef_next.normal[3] = cfg_data;
                tmbk_pkg::REG_SKEW_DIPOLE:   coef_next.skew[0]   = cfg_data;
                tmbk_pkg::REG_SKEW_QUAD:     coef_next.skew[1]   = cfg_data;
                tmbk_pkg::REG_SKEW_SEXT:     coef_next.skew[2]   = cfg_data;
                tmbk_pkg::REG_SKEW_OCT:      coef_next.skew[3]   = cfg_data;
                default:                     coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

/* rtl/tmbk_fmul.sv */
`timescale 1ns / 1ps
// Fixed-point product in three stages: four partial products of up to 25x25 bits, their
// exact 96-bit sum, then the floor shift by FRAC_BITS and saturation.
module tmbk_fmul #(
    parameter int FRAC_BITS = 32
) (
    input  logic                                 clk,
    input  logic [tmbk_pkg::FMUL_STAGES-1:0]     en,
    input  tmbk_pkg::val_t                       a,
    input  tmbk_pkg::val_t                       b,
    output tmbk_pkg::val_t                       p
);

    localparam int HW = tmbk_pkg::HALF_W;
    localparam int VW = tmbk_pkg::VAL_W;
    localparam int PW = tmbk_pkg::PART_W;
    localparam int QW = tmbk_pkg::PROD_W;

    logic signed [HW:0]   a_lo;
    logic signed [HW:0]   b_lo;
    logic signed [HW-1:0] a_hi;
    logic signed [HW-1:0] b_hi;

    logic signed [PW-1:0] ll_next, lh_next, hl_next, hh_next;
    logic signed [PW-1:0] ll_reg, lh_reg, hl_reg, hh_reg;

    logic [QW-1:0] ll_ext, lh_ext, hl_ext, hh_ext, mid;
    logic [QW-1:0] prod_next;
    logic [QW-1:0] prod_reg;

    logic signed [QW-1:0] shifted;
    tmbk_pkg::val_t       p_next;
    tmbk_pkg::val_t       p_reg;

    assign a_lo = {1'b0, a[HW-1:0]};
    assign b_lo = {1'b0, b[HW-1:0]};
    assign a_hi = a[VW-1:HW];
    assign b_hi = b[VW-1:HW];

    assign ll_next = a_lo * b_lo;
    assign lh_next = a_lo * b_hi;
    assign hl_next = a_hi * b_lo;
    assign hh_next = a_hi * b_hi;

    assign ll_ext = {{(QW-PW){ll_reg[PW-1]}}, ll_reg};
    assign lh_ext = {{(QW-PW){lh_reg[PW-1]}}, lh_reg};
    assign hl_ext = {{(QW-PW){hl_reg[PW-1]}}, hl_reg};
    assign hh_ext = {{(QW-PW){hh_reg[PW-1]}}, hh_reg};
    assign mid    = lh_ext + hl_ext;

    assign prod_next = (hh_ext << (2 * HW)) + (mid << HW) + ll_ext;

    // Arithmetic shift of the exact product rounds toward minus infinity.
    assign shifted = $signed(prod_reg) >>> FRAC_BITS;

    always_comb
    begin
        if (!shifted[QW-1] && (|shifted[QW-2:VW-1]))
        begin
            p_next = tmbk_pkg::VAL_MAX;
        end
        else if (shifted[QW-1] && !(&shifted[QW-2:VW-1]))
        begin
            p_next = tmbk_pkg::VAL_MIN;
        end
        else
        begin
            p_next = shifted[VW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/tmbk_horner_step.sv */
`timescale 1ns / 1ps
// One Horner step: (re + i im) * (x + i y) + (coef_re + i coef_im).
module tmbk_horner_step #(
    parameter int FRAC_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_valid,
    output logic              work_ready,
    input  tmbk_pkg::work_t   work,
    input  tmbk_pkg::val_t    coef_re,
    input  tmbk_pkg::val_t    coef_im,
    output logic              kicked_valid,
    input  logic              kicked_ready,
    output tmbk_pkg::work_t   kicked
);

    localparam int NS = tmbk_pkg::STEP_STAGES;
    localparam int FS = tmbk_pkg::FMUL_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    tmbk_pkg::work_t pay_reg [FS];
    tmbk_pkg::work_t out_next;
    tmbk_pkg::work_t out_reg;

    tmbk_pkg::val_t p_rx, p_iy, p_ix, p_ry;

    // A stage may load when it is empty or when the stage after it moves.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || kicked_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = work_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    assign work_ready   = en[0];
    assign kicked_valid = v_reg[NS-1];
    assign kicked       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_rx (
        .clk(clk), .en(en[FS-1:0]), .a(work.re), .b(work.part.pos_x), .p(p_rx));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_iy (
        .clk(clk), .en(en[FS-1:0]), .a(work.im), .b(work.part.pos_y), .p(p_iy));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ix (
        .clk(clk), .en(en[FS-1:0]), .a(work.im), .b(work.part.pos_x), .p(p_ix));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ry (
        .clk(clk), .en(en[FS-1:0]), .a(work.re), .b(work.part.pos_y), .p(p_ry));

    always_comb
    begin
        out_next      = pay_reg[FS-1];
        out_next.re   = tmbk_pkg::sat_sum(tmbk_pkg::ext(p_rx) - tmbk_pkg::ext(p_iy)
                                          + tmbk_pkg::ext(coef_re));
        out_next.im   = tmbk_pkg::sat_sum(tmbk_pkg::ext(p_ix) + tmbk_pkg::ext(p_ry)
                                          + tmbk_pkg::ext(coef_im));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pay_reg[0] <= work;
        end
        for (int k = 1; k < FS; k++)
        begin
            if (en[k])
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/tmbk_bend.sv */
`timescale 1ns / 1ps
// Applies the field sum to px and py and the dipole bend to px, py and ct.
// The last stage register is the block's output register.
module tmbk_bend #(
    parameter int FRAC_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_valid,
    output logic              work_ready,
    input  tmbk_pkg::work_t   work,
    input  tmbk_pkg::val_t    normal_dipole,
    input  tmbk_pkg::val_t    skew_dipole,
    output logic              result_valid,
    input  logic              result_ready,
    output tmbk_pkg::result_t result
);

    localparam int NS = tmbk_pkg::STEP_STAGES;
    localparam int FS = tmbk_pkg::FMUL_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    tmbk_pkg::work_t   pay_reg [FS];
    tmbk_pkg::result_t out_next;
    tmbk_pkg::result_t out_reg;

    tmbk_pkg::val_t p_bd, p_ad, p_bx, p_ay;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || result_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = work_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    assign work_ready   = en[0];
    assign result_valid = v_reg[NS-1];
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_bd (
        .clk(clk), .en(en[FS-1:0]), .a(normal_dipole), .b(work.part.energy_dev), .p(p_bd));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ad (
        .clk(clk), .en(en[FS-1:0]), .a(skew_dipole), .b(work.part.energy_dev), .p(p_ad));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_bx (
        .clk(clk), .en(en[FS-1:0]), .a(normal_dipole), .b(work.part.pos_x), .p(p_bx));
    tmbk_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ay (
        .clk(clk), .en(en[FS-1:0]), .a(skew_dipole), .b(work.part.pos_y), .p(p_ay));

    always_comb
    begin
        out_next.new_pos_x      = pay_reg[FS-1].part.pos_x;
        out_next.new_pos_y      = pay_reg[FS-1].part.pos_y;
        out_next.new_energy_dev = pay_reg[FS-1].part.energy_dev;
        out_next.bunch_end_out  = pay_reg[FS-1].part.bunch_end;
        out_next.new_angle_x    = tmbk_pkg::sat_sum(
            tmbk_pkg::ext(pay_reg[FS-1].part.angle_x) - tmbk_pkg::ext(pay_reg[FS-1].re)
            + tmbk_pkg::ext(p_bd));
        out_next.new_angle_y    = tmbk_pkg::sat_sum(
            tmbk_pkg::ext(pay_reg[FS-1].part.angle_y) + tmbk_pkg::ext(pay_reg[FS-1].im)
            - tmbk_pkg::ext(p_ad));
        out_next.new_path_len   = tmbk_pkg::sat_sum(
            tmbk_pkg::ext(pay_reg[FS-1].part.path_len) - tmbk_pkg::ext(p_bx)
            + tmbk_pkg::ext(p_ay));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pay_reg[0] <= work;
        end
        for (int k = 1; k < FS; k++)
        begin
            if (en[k])
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/thin_multipole_bend_kick_top.sv */
// Throughput: one particle per cycle while result_ready keeps the output moving; each Horner step
// and the bend unit is a four-stage pipeline around its own four fixed-point multipliers.
// Every stage register empties into the next when that one moves, so bubbles close up.
// Reset clears all stage valid bits and sets every coefficient register to zero.
`timescale 1ns / 1ps
`include "thin_multipole_bend_kick_top_macros.svh"
module thin_multipole_bend_kick_top #(
    parameter int FIELD_ORDER = 3,
    parameter int FRAC_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmbk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  tmbk_pkg::val_t                    cfg_data,
    input  logic                              particle_valid,
    output logic                              particle_ready,
    input  tmbk_pkg::particle_t               particle,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tmbk_pkg::result_t                 result
);

    tmbk_pkg::coef_t coefs;
    tmbk_pkg::work_t chain_item [FIELD_ORDER+1];
    logic [FIELD_ORDER:0] chain_valid;
    logic [FIELD_ORDER:0] chain_ready;

    logic out_free;
    logic cfg_fire;
    logic wr_dipole;
    logic wr_skew_oct;
    logic wr_unmapped;

    tmbk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    assign chain_valid[0]     = particle_valid;
    assign particle_ready     = chain_ready[0];
    assign chain_item[0].part = particle;

    // The Horner sum starts from the highest-order coefficient pair.
    generate
        if (FIELD_ORDER >= 1)
        begin : g_seed
            assign chain_item[0].re = coefs.normal[FIELD_ORDER];
            assign chain_item[0].im = coefs.skew[FIELD_ORDER];
        end
        else
        begin : g_seed_zero
            assign chain_item[0].re = '0;
            assign chain_item[0].im = '0;
        end
    endgenerate

    generate
        for (genvar k = 0; k < FIELD_ORDER; k++)
        begin : g_step
            localparam int CI = FIELD_ORDER - 1 - k;
            tmbk_pkg::val_t c_re;
            tmbk_pkg::val_t c_im;

            // The dipole pair never enters the field sum.
            if (CI == 0)
            begin : g_dipole
                assign c_re = '0;
                assign c_im = '0;
            end
            else
            begin : g_coef
                assign c_re = coefs.normal[CI];
                assign c_im = coefs.skew[CI];
            end

            tmbk_horner_step #(.FRAC_BITS(FRAC_BITS)) u_step (
                .clk          (clk),
                .rst_n        (rst_n),
                .work_valid   (chain_valid[k]),
                .work_ready   (chain_ready[k]),
                .work         (chain_item[k]),
                .coef_re      (c_re),
                .coef_im      (c_im),
                .kicked_valid (chain_valid[k+1]),
                .kicked_ready (chain_ready[k+1]),
                .kicked       (chain_item[k+1])
            );
        end
    endgenerate

    tmbk_bend #(.FRAC_BITS(FRAC_BITS)) u_bend (
        .clk           (clk),
        .rst_n         (rst_n),
        .work_valid    (chain_valid[FIELD_ORDER]),
        .work_ready    (chain_ready[FIELD_ORDER]),
        .work          (chain_item[FIELD_ORDER]),
        .normal_dipole (coefs.normal[0]),
        .skew_dipole   (coefs.skew[0]),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    assign out_free    = !result_valid || result_ready;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign wr_dipole   = cfg_fire && (cfg_index == tmbk_pkg::REG_NORMAL_DIPOLE);
    assign wr_skew_oct = cfg_fire && (cfg_index == tmbk_pkg::REG_SKEW_OCT);
    assign wr_unmapped = cfg_fire && (cfg_index > tmbk_pkg::REG_SKEW_OCT);

    `TMBK_ASSERT_IMP(a_input_open, out_free, particle_ready, "input stalled while output drains")
    `TMBK_ASSERT_NEXT(a_dipole_write, wr_dipole, coefs.normal[0] == $past(cfg_data), "dipole lost")
    `TMBK_ASSERT_NEXT(a_skew_oct_write, wr_skew_oct, coefs.skew[3] == $past(cfg_data), "oct lost")
    `TMBK_ASSERT_NEXT(a_unmapped_write, wr_unmapped, $stable(coefs), "stray write took effect")

endmodule

/* dv/tb_thin_multipole_bend_kick_top.sv */
`timescale 1ns / 1ps
module tb_thin_multipole_bend_kick_top;

    localparam int FIELD_ORDER   = 3;
    localparam int FRAC_BITS     = 32;
    localparam int LATENCY       = 4 * (FIELD_ORDER + 1);
    localparam int IDLE_PCT      = 22;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int HOLD_ITEMS    = 150;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef logic signed [63:0]                 acc_t;
    typedef logic signed [tmbk_pkg::PROD_W-1:0] prod_t;
    typedef logic [tmbk_pkg::CFG_IDX_W-1:0]     idx_t;

    typedef enum int unsigned {MIX_ZERO, MIX_MODERATE, MIX_FULL, MIX_EDGE} mix_e;

    localparam acc_t  ACC_MAX  = acc_t'(tmbk_pkg::VAL_MAX);
    localparam acc_t  ACC_MIN  = acc_t'(tmbk_pkg::VAL_MIN);
    localparam prod_t PROD_MAX = prod_t'(tmbk_pkg::VAL_MAX);
    localparam prod_t PROD_MIN = prod_t'(tmbk_pkg::VAL_MIN);
    localparam tmbk_pkg::val_t ONE   = tmbk_pkg::val_t'(1) << FRAC_BITS;
    localparam tmbk_pkg::val_t HALF  = ONE >>> 1;
    localparam tmbk_pkg::val_t PAT_A = {(tmbk_pkg::VAL_W / 2){2'b01}};
    localparam tmbk_pkg::val_t PAT_B = ~PAT_A;

    localparam idx_t FIRST_UNUSED_REG = tmbk_pkg::REG_SKEW_OCT + 1'b1;
    localparam idx_t LAST_REG_INDEX   = '1;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    idx_t                 cfg_index      = '0;
    tmbk_pkg::val_t       cfg_data       = '0;
    logic                 particle_valid = 1'b0;
    logic                 particle_ready;
    tmbk_pkg::particle_t  particle       = '0;
    logic                 result_valid;
    logic                 result_ready   = 1'b0;
    tmbk_pkg::result_t    result;

    logic                 quiet          = 1'b0;
    logic                 hold_start     = 1'b0;
    int unsigned          hold_count     = 0;

    tmbk_pkg::val_t       normal_coef [tmbk_pkg::NUM_COEF];
    tmbk_pkg::val_t       skew_coef   [tmbk_pkg::NUM_COEF];
    tmbk_pkg::result_t    expected_kicks [$];
    int unsigned          error_count    = 0;

    thin_multipole_bend_kick_top #(
        .FIELD_ORDER(FIELD_ORDER),
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .particle_valid(particle_valid),
        .particle_ready(particle_ready),
        .particle      (particle),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_thin_multipole_bend_kick_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    function automatic tmbk_pkg::val_t clamp(input acc_t v);
        if (v > ACC_MAX)
        begin
            return tmbk_pkg::VAL_MAX;
        end
        if (v < ACC_MIN)
        begin
            return tmbk_pkg::VAL_MIN;
        end
        return tmbk_pkg::val_t'(v);
    endfunction

    // Exact product, floor shift, then saturate.
    function automatic tmbk_pkg::val_t qmul(input tmbk_pkg::val_t a, input tmbk_pkg::val_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b);
        p = p >>> FRAC_BITS;
        if (p > PROD_MAX)
        begin
            return tmbk_pkg::VAL_MAX;
        end
        if (p < PROD_MIN)
        begin
            return tmbk_pkg::VAL_MIN;
        end
        return tmbk_pkg::val_t'(p);
    endfunction

    // Dipole terms never enter the field sum; orders above FIELD_ORDER act as zero.
    function automatic tmbk_pkg::val_t normal_term(input int n);
        return (n >= 1 && n <= FIELD_ORDER && n < tmbk_pkg::NUM_COEF) ? normal_coef[n] : '0;
    endfunction

    function automatic tmbk_pkg::val_t skew_term(input int n);
        return (n >= 1 && n <= FIELD_ORDER && n < tmbk_pkg::NUM_COEF) ? skew_coef[n] : '0;
    endfunction

    function automatic tmbk_pkg::result_t predict_kick(input tmbk_pkg::particle_t p);
        tmbk_pkg::val_t    re;
        tmbk_pkg::val_t    im;
        acc_t              sum_re;
        acc_t              sum_im;
        acc_t              sum_ct;
        tmbk_pkg::result_t r;
        re = normal_term(FIELD_ORDER);
        im = skew_term(FIELD_ORDER);
        for (int i = FIELD_ORDER - 1; i >= 0; i--)
        begin
            sum_re = acc_t'(qmul(re, p.pos_x)) - acc_t'(qmul(im, p.pos_y))
                     + acc_t'(normal_term(i));
            sum_im = acc_t'(qmul(im, p.pos_x)) + acc_t'(qmul(re, p.pos_y))
                     + acc_t'(skew_term(i));
            re = clamp(sum_re);
            im = clamp(sum_im);
        end
        sum_re = acc_t'(p.angle_x) - acc_t'(re) + acc_t'(qmul(normal_coef[0], p.energy_dev));
        sum_im = acc_t'(p.angle_y) + acc_t'(im) - acc_t'(qmul(skew_coef[0], p.energy_dev));
        sum_ct = acc_t'(p.path_len) - acc_t'(qmul(normal_coef[0], p.pos_x))
                 + acc_t'(qmul(skew_coef[0], p.pos_y));
        r.new_pos_x      = p.pos_x;
        r.new_angle_x    = clamp(sum_re);
        r.new_pos_y      = p.pos_y;
        r.new_angle_y    = clamp(sum_im);
        r.new_energy_dev = p.energy_dev;
        r.new_path_len   = clamp(sum_ct);
        r.bunch_end_out  = p.bunch_end;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    function automatic tmbk_pkg::val_t rand_scaled(input int unsigned shift);
        logic signed [63:0] r;
        r = {$urandom, $urandom};
        return tmbk_pkg::val_t'(r >>> shift);
    endfunction

    function automatic tmbk_pkg::val_t pick_value(input mix_e m);
        case (m)
            MIX_ZERO:     return '0;
            MIX_MODERATE: return rand_scaled($urandom_range(24, 44));
            MIX_FULL:     return tmbk_pkg::val_t'({$urandom, $urandom});
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return tmbk_pkg::VAL_MAX;
                    1:       return tmbk_pkg::VAL_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return tmbk_pkg::val_t'(1);
                    default: return ONE;
                endcase
            end
        endcase
    endfunction

    function automatic tmbk_pkg::val_t pick_coef();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
        begin
            return pick_value(MIX_ZERO);
        end
        if (roll < 70)
        begin
            return pick_value(MIX_MODERATE);
        end
        return pick_value(roll < 85 ? MIX_FULL : MIX_EDGE);
    endfunction

    function automatic tmbk_pkg::val_t field_of(input mix_e style);
        if (style == MIX_EDGE && $urandom_range(0, 1) == 0)
        begin
            return pick_value(MIX_MODERATE);
        end
        return pick_value(style);
    endfunction

    function automatic tmbk_pkg::particle_t rand_particle();
        int unsigned         roll;
        mix_e                style;
        tmbk_pkg::particle_t p;
        roll  = $urandom_range(0, 99);
        style = roll < 75 ? MIX_MODERATE : (roll < 90 ? MIX_FULL : MIX_EDGE);
        p.pos_x      = field_of(style);
        p.angle_x    = field_of(style);
        p.pos_y      = field_of(style);
        p.angle_y    = field_of(style);
        p.energy_dev = field_of(style);
        p.path_len   = field_of(style);
        p.bunch_end  = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic tmbk_pkg::particle_t particle_of(
        input tmbk_pkg::val_t x, input tmbk_pkg::val_t px, input tmbk_pkg::val_t y,
        input tmbk_pkg::val_t py, input tmbk_pkg::val_t dl, input tmbk_pkg::val_t ct,
        input logic last);
        tmbk_pkg::particle_t p;
        p.pos_x      = x;
        p.angle_x    = px;
        p.pos_y      = y;
        p.angle_y    = py;
        p.energy_dev = dl;
        p.path_len   = ct;
        p.bunch_end  = last;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic idx_t coef_reg(input bit is_skew, input int n);
        case (n)
            0:       return is_skew ? tmbk_pkg::REG_SKEW_DIPOLE : tmbk_pkg::REG_NORMAL_DIPOLE;
            1:       return is_skew ? tmbk_pkg::REG_SKEW_QUAD   : tmbk_pkg::REG_NORMAL_QUAD;
            2:       return is_skew ? tmbk_pkg::REG_SKEW_SEXT   : tmbk_pkg::REG_NORMAL_SEXT;
            default: return is_skew ? tmbk_pkg::REG_SKEW_OCT    : tmbk_pkg::REG_NORMAL_OCT;
        endcase
    endfunction

    // Leaves cfg_valid high, so it stays asserted between back-to-back writes.
    task automatic write_reg(input idx_t idx, input tmbk_pkg::val_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        for (int n = 0; n < tmbk_pkg::NUM_COEF; n++)
        begin
            if (idx == coef_reg(1'b0, n))
            begin
                normal_coef[n] = data;
            end
            if (idx == coef_reg(1'b1, n))
            begin
                skew_coef[n] = data;
            end
        end
    endtask

    // Writes every coefficient, then a number of writes to indexes past the register list.
    task automatic program_coefs(input tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF],
                                 input tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF],
                                 input int unsigned strays);
        idx_t idx;
        for (int n = 0; n < tmbk_pkg::NUM_COEF; n++)
        begin
            write_reg(coef_reg(1'b0, n), nrm[n]);
            write_reg(coef_reg(1'b1, n), skw[n]);
        end
        for (int s = 0; s < strays; s++)
        begin
            if (s == 0)
            begin
                idx = FIRST_UNUSED_REG;
            end
            else if (s == 1)
            begin
                idx = LAST_REG_INDEX;
            end
            else
            begin
                idx = idx_t'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX));
            end
            write_reg(idx, pick_value(MIX_FULL));
        end
        cfg_valid <= 1'b0;
    endtask

    // Unless quiet, each cycle before an offer idles with a chance of IDLE_PCT percent,
    // so the sender is idle for a random stretch before each offer.
    task automatic send_particle(input tmbk_pkg::particle_t p);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                particle_valid <= 1'b0;
                @(posedge clk);
            end
        end
        particle       <= p;
        particle_valid <= 1'b1;
        @(posedge clk);
        while (!particle_ready)
        begin
            @(posedge clk);
        end
        expected_kicks.push_back(predict_kick(p));
    endtask

    task automatic finish_burst();
        particle_valid <= 1'b0;
        while (expected_kicks.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The receiver stalls at random, never while quiet, and holds off for a
    // counted stretch after a hold request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_count   <= 0;
        end
        else if (hold_start)
        begin
            result_ready <= 1'b0;
            hold_count   <= HOLD_CYCLES;
        end
        else if (hold_count != 0)
        begin
            result_ready <= 1'b0;
            hold_count   <= hold_count - 1;
        end
        else
        begin
            result_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------

    task automatic report_field(input string field, input logic [tmbk_pkg::VAL_W-1:0] want,
                                input logic [tmbk_pkg::VAL_W-1:0] got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        tmbk_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_kicks.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%0t: result transaction with nothing expected", $realtime);
                end
            end
            else
            begin
                want = expected_kicks.pop_front();
                if (result.new_pos_x !== want.new_pos_x)
                    report_field("new_pos_x", want.new_pos_x, result.new_pos_x);
                if (result.new_angle_x !== want.new_angle_x)
                    report_field("new_angle_x", want.new_angle_x, result.new_angle_x);
                if (result.new_pos_y !== want.new_pos_y)
                    report_field("new_pos_y", want.new_pos_y, result.new_pos_y);
                if (result.new_angle_y !== want.new_angle_y)
                    report_field("new_angle_y", want.new_angle_y, result.new_angle_y);
                if (result.new_energy_dev !== want.new_energy_dev)
                    report_field("new_energy_dev", want.new_energy_dev, result.new_energy_dev);
                if (result.new_path_len !== want.new_path_len)
                    report_field("new_path_len", want.new_path_len, result.new_path_len);
                if (result.bunch_end_out !== want.bunch_end_out)
                    report_field("bunch_end_out",
                                 {{(tmbk_pkg::VAL_W-1){1'b0}}, want.bunch_end_out},
                                 {{(tmbk_pkg::VAL_W-1){1'b0}}, result.bunch_end_out});
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All coefficients are zero after reset, so every field passes through.
    task automatic test_reset_pass_through();
        send_particle(particle_of('0, '0, '0, '0, '0, '0, 1'b0));
        send_particle(particle_of(tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX,
                                  tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX,
                                  1'b1));
        send_particle(particle_of(tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN,
                                  tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN,
                                  1'b0));
        send_particle(particle_of(PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, 1'b1));
        send_particle(particle_of('1, '1, '1, '1, '1, '1, 1'b0));
        finish_burst();
    endtask

    // Only the dipole terms are set: they bend, and the field sum stays zero.
    task automatic test_bend_only();
        tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF];
        tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF];
        nrm = '{ONE, '0, '0, '0};
        skw = '{-HALF, '0, '0, '0};
        program_coefs(nrm, skw, 0);
        send_particle(particle_of(ONE, HALF, ONE + ONE, -HALF, ONE / 100, '0, 1'b0));
        send_particle(particle_of(3 * ONE + 7, '0, -ONE - 3, '0, -(ONE / 3) - 1, ONE, 1'b1));
        send_particle(particle_of(tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MIN,
                                  tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MIN,
                                  1'b0));
        send_particle(particle_of(tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MAX,
                                  tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MAX,
                                  1'b1));
        finish_burst();
    endtask

    // Writes past the register list must leave every coefficient alone.
    task automatic test_unused_index();
        tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF];
        tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF];
        nrm = '{ONE, HALF, -ONE, ONE >>> 2};
        skw = '{HALF >>> 3, -HALF, ONE >>> 4, -(ONE >>> 2)};
        program_coefs(nrm, skw, 2);
        send_particle(particle_of(HALF, ONE, -HALF, -ONE, ONE >>> 5, 2 * ONE, 1'b0));
        send_particle(particle_of(-ONE, '0, ONE + HALF, '0, -(ONE >>> 3), '0, 1'b1));
        finish_burst();
    endtask

    // Extreme coefficients drive every Horner stage into saturation; then a
    // tiny negative coefficient checks that products round toward minus infinity.
    task automatic test_saturation_and_floor();
        tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF];
        tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF];
        nrm = '{tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MAX};
        skw = '{tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MIN, tmbk_pkg::VAL_MAX, tmbk_pkg::VAL_MAX};
        program_coefs(nrm, skw, 0);
        send_particle(particle_of(tmbk_pkg::VAL_MAX, '0, tmbk_pkg::VAL_MAX, '0,
                                  tmbk_pkg::VAL_MAX, '0, 1'b0));
        send_particle(particle_of(tmbk_pkg::VAL_MAX, '0, tmbk_pkg::VAL_MIN, '0, ONE, '0, 1'b1));
        send_particle(particle_of(ONE, '0, -ONE, '0, '0, '0, 1'b0));
        send_particle(particle_of('0, '0, '0, '0, '0, '0, 1'b1));
        finish_burst();
        nrm = '{'1, '1, '1, '1};
        skw = '{'1, '1, '1, '1};
        program_coefs(nrm, skw, 0);
        send_particle(particle_of(tmbk_pkg::val_t'(3), tmbk_pkg::val_t'(5),
                                  -tmbk_pkg::val_t'(7), tmbk_pkg::val_t'(11),
                                  tmbk_pkg::val_t'(13), -tmbk_pkg::val_t'(17), 1'b0));
        send_particle(particle_of(HALF, -HALF, HALF + 1, ONE - 1, -HALF, HALF, 1'b1));
        finish_burst();
    endtask

    task automatic test_random_phase(input int unsigned n_items, input bit no_idle);
        tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF];
        tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF];
        for (int n = 0; n < tmbk_pkg::NUM_COEF; n++)
        begin
            nrm[n] = pick_coef();
            skw[n] = pick_coef();
        end
        program_coefs(nrm, skw, $urandom_range(0, 1));
        quiet <= no_idle;
        repeat (n_items) send_particle(rand_particle());
        finish_burst();
        quiet <= 1'b0;
    endtask

    // The receiver holds off while particles keep coming, so the pipeline fills
    // and must stall its input.
    task automatic test_backpressure();
        tmbk_pkg::val_t nrm [tmbk_pkg::NUM_COEF];
        tmbk_pkg::val_t skw [tmbk_pkg::NUM_COEF];
        for (int n = 0; n < tmbk_pkg::NUM_COEF; n++)
        begin
            nrm[n] = pick_value(MIX_MODERATE);
            skw[n] = pick_value(MIX_MODERATE);
        end
        program_coefs(nrm, skw, 0);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (HOLD_ITEMS) send_particle(rand_particle());
        finish_burst();
    endtask

    initial
    begin
        for (int n = 0; n < tmbk_pkg::NUM_COEF; n++)
        begin
            normal_coef[n] = '0;
            skew_coef[n]   = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pass_through();
        test_bend_only();
        test_unused_index();
        test_saturation_and_floor();
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            test_random_phase(PHASE_ITEMS, k == 2);
        end
        test_backpressure();

        repeat (LATENCY + 8) @(posedge clk);
        if (expected_kicks.size() != 0)
        begin
            error_count += expected_kicks.size();
            $display("%0d expected results never arrived", expected_kicks.size());
        end
        if (error_count == 0)
        begin
            $display("tb_thin_multipole_bend_kick_top: done, clean");
        end
        else
        begin
            $display("tb_thin_multipole_bend_kick_top: done, errors");
        end
        $finish;
    end

endmodule
